FILE: hw/rtl/circle_zone_evaluator_defines.svh
// assertion macros shared by the circle zone evaluator rtl
`ifndef CIRCLE_ZONE_EVALUATOR_DEFINES_SVH
`define CIRCLE_ZONE_EVALUATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define CZE_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("circle zone evaluator assertion failed");
`define CZE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("circle zone evaluator assertion failed");
`else
`define CZE_ASSERT(lbl, expr)
`define CZE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/czone_pkg.sv
// shared constants, codes and types of the circle zone evaluator
package czone_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int R_W         = 16;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_W       = 18;

    localparam int SQ_W      = 2 * COORD_WIDTH;
    localparam int D2_W      = 2 * COORD_WIDTH + 1;
    localparam int ROOT_W    = COORD_WIDTH + 1;
    localparam int RSQ_W     = 2 * R_W;
    localparam int OUTER_W   = R_W + 2;
    localparam int INNER_W   = R_W + 1;
    localparam int IN_CMP_W  = (D2_W > RSQ_W) ? D2_W : RSQ_W;
    localparam int BD_CMP_W  = ((D2_W + 2) > (2 * OUTER_W)) ? (D2_W + 2) : (2 * OUTER_W);
    localparam int DIST_W    = ((ROOT_W > R_W) ? ROOT_W : R_W) + 1;

    // zone kind codes
    localparam logic [KIND_W-1:0] KIND_INSIDE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BORDER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIST   = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ZONE_KIND = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MARGIN    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [COORD_WIDTH-1:0] center_x;
        logic [COORD_WIDTH-1:0] center_y;
        logic [R_W-1:0]         radius;
        logic [R_W-1:0]         margin;
    } czone_cfg_t;

    // one word moving down the root cell chain
    typedef struct packed {
        logic            valid;
        logic            in_circle;
        logic            border;
        logic [D2_W-1:0] rem;
        logic [D2_W-1:0] root;
    } czone_word_t;

endpackage

FILE: hw/rtl/circle_zone_evaluator.sv
// top level of the circle zone evaluator: registers, root cell chain, output stage
// pipeline: 4 front stages, then one root cell per result bit of the square root, 17 here,
//   then the output register
// throughput: one sample per cycle; every stage moves together, held only while
//   a result word waits at the output
// reset: synchronous active-low aresetn clears all pipeline valids and config registers to 0
`include "circle_zone_evaluator_defines.svh"

module circle_zone_evaluator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [czone_pkg::COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [czone_pkg::COORD_WIDTH-1:0] s_pos_y,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [czone_pkg::OUT_W-1:0]    m_zone_value,
    // register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [czone_pkg::IDX_W-1:0]           cfg_index,
    input  logic [czone_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NCELL = czone_pkg::ROOT_W;

    // configuration registers
    czone_pkg::czone_cfg_t cfg_reg, cfg_next;

    // whole pipeline steps when the output register is empty or being drained
    logic advance;

    // word chain: entry 0 comes from the front pipeline, entry NCELL leaves the last cell
    czone_pkg::czone_word_t chain_word [NCELL+1];

    // output stage
    logic                               m_valid_reg, m_valid_next;
    logic signed [czone_pkg::OUT_W-1:0] m_zone_value_reg, m_zone_value_next;
    logic signed [czone_pkg::DIST_W-1:0] dist_val;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                czone_pkg::REG_ZONE_KIND: cfg_next.kind     = cfg_data[czone_pkg::KIND_W-1:0];
                czone_pkg::REG_CENTER_X:  cfg_next.center_x = cfg_data[czone_pkg::COORD_WIDTH-1:0];
                czone_pkg::REG_CENTER_Y:  cfg_next.center_y = cfg_data[czone_pkg::COORD_WIDTH-1:0];
                czone_pkg::REG_RADIUS:    cfg_next.radius   = cfg_data[czone_pkg::R_W-1:0];
                czone_pkg::REG_MARGIN:    cfg_next.margin   = cfg_data[czone_pkg::R_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // offsets, squares and both zone compares
    czone_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .s_valid  (s_valid),
        .s_pos_x  (s_pos_x),
        .s_pos_y  (s_pos_y),
        .cfg      (cfg_reg),
        .word_out (chain_word[0])
    );

    // root chain: cell k settles one root bit, trial bit weight 4^(NCELL-1-k)
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        czone_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .step_bit (czone_pkg::D2_W'(1) << (2 * (NCELL - 1 - k))),
            .word_in  (chain_word[k]),
            .word_out (chain_word[k+1])
        );
    end

    // pick the answer for the configured zone kind
    always_comb begin
        dist_val = czone_pkg::DIST_W'(chain_word[NCELL].root[czone_pkg::ROOT_W-1:0])
                 - czone_pkg::DIST_W'(cfg_reg.radius);
        m_valid_next = chain_word[NCELL].valid;
        unique case (cfg_reg.kind)
            czone_pkg::KIND_INSIDE: m_zone_value_next = czone_pkg::OUT_W'(chain_word[NCELL].in_circle);
            czone_pkg::KIND_BORDER: m_zone_value_next = czone_pkg::OUT_W'(chain_word[NCELL].border);
            czone_pkg::KIND_DIST:   m_zone_value_next = czone_pkg::OUT_W'(dist_val);
            default:                m_zone_value_next = '0;  // unused kind answers zero
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_zone_value_reg <= m_zone_value_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_zone_value = m_zone_value_reg;

    // the root leaving the chain leaves a remainder of at most twice itself
    `CZE_ASSERT(a_root_rem_bound, !chain_word[NCELL].valid || (chain_word[NCELL].rem <= (chain_word[NCELL].root << 1)))
    // a result word only appears when the chain delivered one
    `CZE_ASSERT_NEXT(a_out_from_chain, !m_valid_reg && advance && !chain_word[NCELL].valid, !m_valid_reg)
    // a held result freezes the whole chain
    `CZE_ASSERT_NEXT(a_stall_holds_chain, m_valid_reg && !m_ready, $stable(chain_word[NCELL]) && $stable(chain_word[0]))

endmodule

FILE: hw/rtl/czone_front.sv
// front pipeline: offsets, squares, squared distance and zone compares
module czone_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic                             s_valid,
    input  logic signed [czone_pkg::COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [czone_pkg::COORD_WIDTH-1:0] s_pos_y,
    input  czone_pkg::czone_cfg_t            cfg,
    output czone_pkg::czone_word_t           word_out
);

    localparam int W = czone_pkg::COORD_WIDTH;

    // stage 1
    logic                              v1_reg, v1_next;
    logic [W-1:0]                      dx_reg, dx_next, dy_reg, dy_next;
    logic [czone_pkg::OUTER_W-1:0]     outer_reg, outer_next;
    logic [czone_pkg::INNER_W-1:0]     inner_reg, inner_next;
    logic [W:0]                        diff_x, diff_y;
    logic [czone_pkg::INNER_W-1:0]     two_r, m_ext;

    // stage 2
    logic                              v2_reg, v2_next;
    logic [czone_pkg::SQ_W-1:0]        sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [czone_pkg::RSQ_W-1:0]       r2a_reg, r2a_next;
    logic [2*czone_pkg::OUTER_W-1:0]   o2a_reg, o2a_next;
    logic [2*czone_pkg::INNER_W-1:0]   i2a_reg, i2a_next;

    // stage 3
    logic                              v3_reg, v3_next;
    logic [czone_pkg::D2_W-1:0]        d2_reg, d2_next;
    logic [czone_pkg::RSQ_W-1:0]       r2b_reg, r2b_next;
    logic [2*czone_pkg::OUTER_W-1:0]   o2b_reg, o2b_next;
    logic [2*czone_pkg::INNER_W-1:0]   i2b_reg, i2b_next;

    // stage 4
    czone_pkg::czone_word_t            w4_reg, w4_next;
    logic [czone_pkg::BD_CMP_W-1:0]    d4;

    always_comb begin
        v1_next = s_valid;
        diff_x  = {s_pos_x[W-1], s_pos_x} - {cfg.center_x[W-1], cfg.center_x};
        diff_y  = {s_pos_y[W-1], s_pos_y} - {cfg.center_y[W-1], cfg.center_y};
        dx_next = diff_x[W] ? (~diff_x[W-1:0] + W'(1)) : diff_x[W-1:0];
        dy_next = diff_y[W] ? (~diff_y[W-1:0] + W'(1)) : diff_y[W-1:0];
        outer_next = (czone_pkg::OUTER_W'(cfg.radius) << 1)
                   + czone_pkg::OUTER_W'(cfg.margin);
        two_r = czone_pkg::INNER_W'(cfg.radius) << 1;
        m_ext = czone_pkg::INNER_W'(cfg.margin);
        inner_next = (two_r >= m_ext) ? (two_r - m_ext) : (m_ext - two_r);
    end

    always_comb begin
        v2_next  = v1_reg;
        sqx_next = czone_pkg::SQ_W'(dx_reg) * czone_pkg::SQ_W'(dx_reg);
        sqy_next = czone_pkg::SQ_W'(dy_reg) * czone_pkg::SQ_W'(dy_reg);
        r2a_next = czone_pkg::RSQ_W'(cfg.radius) * czone_pkg::RSQ_W'(cfg.radius);
        o2a_next = (2*czone_pkg::OUTER_W)'(outer_reg) * (2*czone_pkg::OUTER_W)'(outer_reg);
        i2a_next = (2*czone_pkg::INNER_W)'(inner_reg) * (2*czone_pkg::INNER_W)'(inner_reg);
    end

    always_comb begin
        v3_next  = v2_reg;
        d2_next  = czone_pkg::D2_W'(sqx_reg) + czone_pkg::D2_W'(sqy_reg);
        r2b_next = r2a_reg;
        o2b_next = o2a_reg;
        i2b_next = i2a_reg;
    end

    always_comb begin
        d4 = czone_pkg::BD_CMP_W'(d2_reg) << 2;
        w4_next.valid     = v3_reg;
        w4_next.in_circle = czone_pkg::IN_CMP_W'(d2_reg) <= czone_pkg::IN_CMP_W'(r2b_reg);
        w4_next.border    = (d4 <= czone_pkg::BD_CMP_W'(o2b_reg))
                         && (d4 >  czone_pkg::BD_CMP_W'(i2b_reg));
        w4_next.rem       = d2_reg;
        w4_next.root      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            w4_reg.valid <= 1'b0;
        end else if (advance) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            w4_reg <= w4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            r2a_reg   <= r2a_next;
            o2a_reg   <= o2a_next;
            i2a_reg   <= i2a_next;
            d2_reg    <= d2_next;
            r2b_reg   <= r2b_next;
            o2b_reg   <= o2b_next;
            i2b_reg   <= i2b_next;
        end
    end

    assign word_out = w4_reg;

endmodule

FILE: hw/rtl/czone_sqrt_cell.sv
// one cell of the root chain: one restoring square root step per word
module czone_sqrt_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic [czone_pkg::D2_W-1:0]       step_bit,
    input  czone_pkg::czone_word_t           word_in,
    output czone_pkg::czone_word_t           word_out
);

    czone_pkg::czone_word_t          word_reg, word_next;
    logic [czone_pkg::D2_W:0]        trial;
    logic                            take;

    always_comb begin
        trial     = {1'b0, word_in.root} + {1'b0, step_bit};
        take      = {1'b0, word_in.rem} >= trial;
        word_next = word_in;
        if (take) begin
            word_next.rem  = word_in.rem - trial[czone_pkg::D2_W-1:0];
            word_next.root = (word_in.root >> 1) + step_bit;
        end else begin
            word_next.root = word_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (advance) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: test/tb.sv
// self-checking testbench of the circle zone evaluator: directed and random sample words
module tb;
    import czone_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int LATENCY      = 22;       // sample accepted to result word
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest correct run
    localparam int IDLE_PCT     = 17;       // chance per cycle that a side holds back
    localparam int REPORT_CAP   = 100;      // keep the log short on a badly broken build
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 70;
    localparam int CALM_PHASE   = 5;        // phase run with no idling on either side
    localparam int SPARE_PHASE  = 7;        // phase run with the unused zone kind
    localparam int EDGE_PHASE   = 10;       // phase with the center pinned to a corner

    // zone kind code with no meaning; the block must answer zero
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]       zone_t;

    // one expected result word, with the sample that caused it for the log
    typedef struct {
        coord_t            pos_x;
        coord_t            pos_y;
        logic [KIND_W-1:0] kind;
        zone_t             value;
    } zone_due_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    coord_t                s_pos_x   = '0;
    coord_t                s_pos_y   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    zone_t                 m_zone_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    czone_cfg_t circle = '0;    // predictor copy of the register file
    zone_due_t  zone_queue[$];  // results still owed by the block
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         calm        = 1'b0;  // set while neither side may idle

    circle_zone_evaluator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_zone_value (m_zone_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("circle_zone_evaluator regression: fail");
        $finish;
    end

    // result side stalls at random, except in the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_mismatch(string what);
        if (mismatches < REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // integer square root, one result bit per step from the top
    function automatic longint floor_root(longint n);
        longint root = 0;
        longint trial;
        for (int b = ROOT_W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // zone answer for one sample under the current register copy
    function automatic zone_t predict_zone(coord_t px, coord_t py);
        longint dx;
        longint dy;
        longint d2;
        longint r;
        longint m;
        longint outer;
        longint inner;
        dx = longint'(px) - longint'($signed(circle.center_x));
        dy = longint'(py) - longint'($signed(circle.center_y));
        d2 = dx * dx + dy * dy;
        r  = longint'(circle.radius);
        m  = longint'(circle.margin);
        // band compared at doubled scale so an odd margin stays exact
        outer = 2 * r + m;
        // inner bound folds over when the margin is wider than the diameter
        inner = (2 * r >= m) ? (2 * r - m) : (m - 2 * r);
        case (circle.kind)
            KIND_INSIDE: return (d2 <= r * r) ? zone_t'(1) : zone_t'(0);
            KIND_BORDER: begin
                return (4 * d2 <= outer * outer && 4 * d2 > inner * inner) ?
                       zone_t'(1) : zone_t'(0);
            end
            KIND_DIST:   return zone_t'(floor_root(d2) - r);
            default:     return zone_t'(0);
        endcase
    endfunction

    // checker: settle the oldest debt first, then book the sample taken at this edge
    always @(posedge aclk) begin : check_words
        zone_due_t due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (zone_queue.size() == 0) begin
                    report_mismatch($sformatf("result word %0d with no sample pending",
                                              m_zone_value));
                end else begin
                    due = zone_queue.pop_front();
                    if (m_zone_value !== due.value)
                        report_mismatch($sformatf(
                            "kind %0d sample (%0d,%0d): zone_value %0d, want %0d",
                            due.kind, due.pos_x, due.pos_y, m_zone_value, due.value));
                end
            end
            if (s_valid && s_ready)
                zone_queue.push_back('{s_pos_x, s_pos_y, circle.kind,
                                       predict_zone(s_pos_x, s_pos_y)});
        end
    end

    // one sample word; valid stays up on return so back-to-back words need no gap
    task automatic send_sample(coord_t px, coord_t py);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every owed result is back; the first edge lets the checker book
    // a sample taken at the edge this was called on
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (zone_queue.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // one register write; junk in the unused upper data bits must be ignored
    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom();
        if (idx == REG_ZONE_KIND)
            word[KIND_W-1:0] = value[KIND_W-1:0];
        else
            word[R_W-1:0] = value[R_W-1:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ZONE_KIND: circle.kind     = word[KIND_W-1:0];
            REG_CENTER_X:  circle.center_x = word[COORD_WIDTH-1:0];
            REG_CENTER_Y:  circle.center_y = word[COORD_WIDTH-1:0];
            REG_RADIUS:    circle.radius   = word[R_W-1:0];
            REG_MARGIN:    circle.margin   = word[R_W-1:0];
            default: ;
        endcase
    endtask

    // full reprogram, only once the pipeline is empty
    task automatic set_circle(logic [KIND_W-1:0] kind, int cx, int cy, int r, int m);
        drain_results();
        write_reg(REG_ZONE_KIND, kind);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, r);
        write_reg(REG_MARGIN, m);
        cfg_valid <= 1'b0;
    endtask

    // registers still at reset: circle of radius zero at the origin
    task automatic test_reset_state();
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(-32768, 32767);
    endtask

    task automatic test_inside();
        set_circle(KIND_INSIDE, 100, -200, 5, 0);
        send_sample(103, -196);    // exactly on the circle
        send_sample(104, -196);    // just outside
        send_sample(100, -200);    // center
        // widest spread: opposite corners against the largest radius
        set_circle(KIND_INSIDE, -32768, -32768, 65535, 65535);
        send_sample(32767, 32767);
        send_sample(32767, -32768);
    endtask

    task automatic test_border();
        // even margin, band 8 .. 12, lower edge open, upper edge closed
        set_circle(KIND_BORDER, 0, 0, 10, 4);
        send_sample(8, 0);
        send_sample(9, 0);
        send_sample(12, 0);
        send_sample(13, 0);
        // odd margin, band 7.5 .. 12.5 with no rounding
        set_circle(KIND_BORDER, -5, 7, 10, 5);
        send_sample(2, 10);
        send_sample(2, 9);
        send_sample(7, 11);
        // margin wider than the diameter, inner bound folds back to 2
        set_circle(KIND_BORDER, 0, 0, 3, 10);
        send_sample(1, 0);
        send_sample(5, 0);
        send_sample(8, 0);
    endtask

    task automatic test_distance();
        set_circle(KIND_DIST, -32768, -32768, 0, 0);
        send_sample(32767, 32767);     // largest root
        send_sample(-32768, -32768);
        set_circle(KIND_DIST, 32767, 32767, 65535, 0);
        send_sample(32767, 32767);     // most negative answer
        send_sample(32767, 32764);
    endtask

    // unused zone kind answers zero; writes past the last register change nothing
    task automatic test_spare_codes();
        set_circle(KIND_UNUSED, 1, 2, 3, 4);
        send_sample(1, 2);
        set_circle(KIND_INSIDE, 0, 0, 3, 0);
        for (int idx = REG_MARGIN + 1; idx < 2 ** IDX_W; idx++)
            write_reg(idx[IDX_W-1:0], $urandom());
        cfg_valid <= 1'b0;
        send_sample(3, 0);
        send_sample(4, 0);
    endtask

    // random phases: each picks a circle, then mostly samples near its edge or band
    task automatic test_random_phases();
        logic [KIND_W-1:0] kind_cycle[3] = '{KIND_INSIDE, KIND_BORDER, KIND_DIST};
        logic [KIND_W-1:0] kind;
        int     cx;
        int     cy;
        int     r;
        int     m;
        int     spread;
        longint target;
        longint dx;
        longint dy;
        for (int ph = 0; ph < PHASES; ph++) begin
            kind = (ph == SPARE_PHASE) ? KIND_UNUSED : kind_cycle[ph % 3];
            case (ph % 4)
                0: r = $urandom_range(0, 3);
                1: r = $urandom_range(4, 300);
                2: r = $urandom_range(301, 65535);
                default: r = 65535;
            endcase
            case ($urandom_range(0, 4))
                0: m = 0;
                1: m = 65535;
                2: m = $urandom_range(1, 9);
                3: m = $urandom_range(0, (2 * r + 2 > 65535) ? 65535 : 2 * r + 2);
                default: m = $urandom_range(0, 65535);
            endcase
            if (ph == EDGE_PHASE) begin
                cx = 32767;
                cy = -32768;
            end else begin
                cx = int'($urandom_range(0, 65535)) - 32768;
                cy = int'($urandom_range(0, 65535)) - 32768;
            end
            set_circle(kind, cx, cy, r, m);
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 70) begin
                    // aim at the circle, or anywhere across the band in border mode
                    if (kind == KIND_BORDER)
                        spread = m / 2 + 2;
                    else
                        spread = 2;
                    target = longint'(r) + int'($urandom_range(0, 2 * spread)) - spread;
                    if (target < 0)
                        target = 0;
                    dx = $urandom_range(0, int'(target));
                    dy = floor_root(target * target - dx * dx)
                         + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(1))
                        dx = -dx;
                    if ($urandom_range(1))
                        dy = -dy;
                    // coordinates wrap at the field width, which is fine as noise
                    send_sample(coord_t'(cx + dx), coord_t'(cy + dy));
                end else begin
                    send_sample(coord_t'($urandom()), coord_t'($urandom()));
                end
            end
            drain_results();
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_inside();
        test_border();
        test_distance();
        test_spare_codes();
        test_random_phases();

        drain_results();
        repeat (LATENCY + 8) @(posedge aclk);
        if (zone_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", zone_queue.size()));
        if (mismatches == 0)
            $display("circle_zone_evaluator regression: pass");
        else
            $display("circle_zone_evaluator regression: fail");
        $finish;
    end

endmodule
